@@ rtl/uart_baud_divisor_calc_macros.svh @@
// ---------------------------------------------------------------------------
// uart_baud_divisor_calc_macros
// assertion macros shared by the baud divisor calculator
// ---------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UBDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define UBDC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/ubdc_pkg.sv @@
// ---------------------------------------------------------------------------
// ubdc_pkg
// widths, reset values and the divider step shared by the baud calculator
// ---------------------------------------------------------------------------
package ubdc_pkg;

    localparam int RATE_W    = 24;
    localparam int CLK_W     = 27;
    localparam int MANT_W    = 12;
    localparam int FRAC_W    = 4;
    localparam int BRR_W     = MANT_W + FRAC_W;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // quotient bits of 2*clock/rate kept before saturation
    localparam int QUO_W     = 18;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / STEPS_PER_STAGE;

    // high dividend bits that seed the partial remainder
    localparam int SEED_W    = CLK_W + 1 - QUO_W;

    localparam logic [CLK_W-1:0]  CLOCK_RESET    = CLK_W'(16000000);
    localparam logic [RATE_W-1:0] MAX_RATE_RESET = RATE_W'(2000000);

    // register index codes (paddr word index)
    localparam logic REG_CLOCK_HZ = 1'b0;
    localparam logic REG_MAX_RATE = 1'b1;

    localparam logic [MANT_W-1:0] MANT_MAX = '1;
    localparam logic [FRAC_W-1:0] FRAC_MAX_BY8  = FRAC_W'(7);
    localparam logic [FRAC_W-1:0] FRAC_MAX_BY16 = FRAC_W'(15);

    typedef struct packed {
        logic              zero;
        logic              ovf;
        logic              by8;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] rem;
        logic [QUO_W-1:0]  work;
    } div_t;

    // one restoring step: shift in a dividend bit, shift out a quotient bit
    function automatic div_t div_step(div_t d);
        logic [RATE_W:0] t;
        logic [RATE_W:0] diff;
        logic            qbit;
        div_t            r;
        t    = {d.rem, d.work[QUO_W-1]};
        diff = t - {1'b0, d.rate};
        qbit = (t >= {1'b0, d.rate});
        r      = d;
        r.rem  = qbit ? diff[RATE_W-1:0] : t[RATE_W-1:0];
        r.work = {d.work[QUO_W-2:0], qbit};
        return r;
    endfunction

endpackage

@@ rtl/uart_baud_divisor_calc.sv @@
// ---------------------------------------------------------------------------
// uart_baud_divisor_calc
// turns a requested baud rate into a uart divisor word
// ---------------------------------------------------------------------------
// Accepts one item every clock cycle (busy is always low) and returns its
// result as a one-cycle done pulse; results come out in order and cannot
// be stalled. Each item passes two front stages for mode selection,
// clamping and divider seeding, then the 18-bit restoring divider for
// 2*clock/rate, which resolves two quotient bits per stage over nine
// stages, and one output stage for rounding and saturation. Write clock_hz
// (address 0) and max_rate (address 4) only while no item is in flight.
module uart_baud_divisor_calc
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ubdc_pkg::RATE_W-1:0]   baud_rate,
    output logic                          done,
    output logic                          oversample_by_8,
    output logic [ubdc_pkg::MANT_W-1:0]   mantissa,
    output logic [ubdc_pkg::FRAC_W-1:0]   fraction,
    output logic [ubdc_pkg::BRR_W-1:0]    brr_word,
    output logic                          rate_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ubdc_pkg::DATA_W-1:0]   pwdata,
    output logic [ubdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [ubdc_pkg::CLK_W-1:0]  clock_hz_reg;
    logic [ubdc_pkg::RATE_W-1:0] max_rate_reg;
    logic                        cfg_wr;
    logic                        accept;

    logic                        valid_chain [0:ubdc_pkg::DIV_STAGES];
    ubdc_pkg::div_t              data_chain  [0:ubdc_pkg::DIV_STAGES];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= ubdc_pkg::CLOCK_RESET;
            max_rate_reg <= ubdc_pkg::MAX_RATE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ubdc_pkg::REG_CLOCK_HZ: clock_hz_reg <= pwdata[ubdc_pkg::CLK_W-1:0];
                ubdc_pkg::REG_MAX_RATE: max_rate_reg <= pwdata[ubdc_pkg::RATE_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ubdc_pkg::REG_CLOCK_HZ:
                prdata = {{(ubdc_pkg::DATA_W-ubdc_pkg::CLK_W){1'b0}}, clock_hz_reg};
            ubdc_pkg::REG_MAX_RATE:
                prdata = {{(ubdc_pkg::DATA_W-ubdc_pkg::RATE_W){1'b0}}, max_rate_reg};
            default:
                prdata = '0;
        endcase
    end

    ubdc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .baud_rate (baud_rate),
        .clock_hz  (clock_hz_reg),
        .max_rate  (max_rate_reg),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar g = 0; g < ubdc_pkg::DIV_STAGES; g++)
    begin : g_div
        ubdc_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[g]),
            .in_data   (data_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_data  (data_chain[g+1])
        );
    end

    ubdc_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (valid_chain[ubdc_pkg::DIV_STAGES]),
        .in_data         (data_chain[ubdc_pkg::DIV_STAGES]),
        .done            (done),
        .oversample_by_8 (oversample_by_8),
        .mantissa        (mantissa),
        .fraction        (fraction),
        .brr_word        (brr_word),
        .rate_error      (rate_error)
    );

`include "uart_baud_divisor_calc_macros.svh"

    `UBDC_ASSERT_NEVER(a_by8_frac_range, done && oversample_by_8 && fraction[3], "by-8 fraction above 7")
    `UBDC_ASSERT_IMPL(a_err_fields, done && rate_error, (mantissa == ubdc_pkg::MANT_MAX) || (brr_word == '0), "error result neither saturated nor zero")
    `UBDC_ASSERT_IMPL(a_sat_flag, done && (mantissa == ubdc_pkg::MANT_MAX) && (fraction == ubdc_pkg::FRAC_MAX_BY16), rate_error || (brr_word == 16'hFFFF), "brr word does not match saturated fields")

endmodule

@@ rtl/ubdc_front.sv @@
// ---------------------------------------------------------------------------
// ubdc_front
// picks the oversampling mode, clamps the rate and seeds the divider
// ---------------------------------------------------------------------------
module ubdc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ubdc_pkg::RATE_W-1:0]   baud_rate,
    input  logic [ubdc_pkg::CLK_W-1:0]    clock_hz,
    input  logic [ubdc_pkg::RATE_W-1:0]   max_rate,
    output logic                          out_valid,
    output ubdc_pkg::div_t                out_data
);

    logic                        v1_reg;
    logic                        by8_reg;
    logic                        by8_next;
    logic [ubdc_pkg::RATE_W-1:0] rate_reg;
    logic [ubdc_pkg::RATE_W-1:0] rate_next;
    logic                        v2_reg;
    ubdc_pkg::div_t              data_reg;
    ubdc_pkg::div_t              data_next;
    logic                        over16;
    logic                        over8;

    assign over16 = ({baud_rate, 4'b0} > {1'b0, clock_hz});
    assign over8  = ({1'b0, baud_rate, 3'b0} > {1'b0, clock_hz});

    always_comb
    begin
        by8_next  = 1'b0;
        rate_next = baud_rate;
        if (over16 && (baud_rate != '0))
        begin
            by8_next = 1'b1;
            if (over8)
            begin
                rate_next = max_rate;
            end
        end
    end

    // seed remainder holds the top dividend bits of 2*clock; ovf flags a seed not below the rate
    always_comb
    begin
        data_next.zero = (rate_reg == '0);
        data_next.ovf  = ({{(ubdc_pkg::RATE_W-ubdc_pkg::SEED_W){1'b0}},
                           clock_hz[ubdc_pkg::CLK_W-1 -: ubdc_pkg::SEED_W]} >= rate_reg);
        data_next.by8  = by8_reg;
        data_next.rate = rate_reg;
        data_next.rem  = {{(ubdc_pkg::RATE_W-ubdc_pkg::SEED_W){1'b0}},
                          clock_hz[ubdc_pkg::CLK_W-1 -: ubdc_pkg::SEED_W]};
        data_next.work = {clock_hz[ubdc_pkg::QUO_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        by8_reg  <= by8_next;
        rate_reg <= rate_next;
        data_reg <= data_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/ubdc_div_stage.sv @@
// ---------------------------------------------------------------------------
// ubdc_div_stage
// one pipeline stage of the restoring divider, two quotient bits deep
// ---------------------------------------------------------------------------
module ubdc_div_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ubdc_pkg::div_t in_data,
    output logic           out_valid,
    output ubdc_pkg::div_t out_data
);

    logic           valid_reg;
    ubdc_pkg::div_t data_reg;
    ubdc_pkg::div_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < ubdc_pkg::STEPS_PER_STAGE; i++)
        begin
            data_next = ubdc_pkg::div_step(data_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/ubdc_back.sv @@
// ---------------------------------------------------------------------------
// ubdc_back
// rounds the quotient, splits mantissa and fraction, saturates and flags zero rates
// ---------------------------------------------------------------------------
module ubdc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  ubdc_pkg::div_t                in_data,
    output logic                          done,
    output logic                          oversample_by_8,
    output logic [ubdc_pkg::MANT_W-1:0]   mantissa,
    output logic [ubdc_pkg::FRAC_W-1:0]   fraction,
    output logic [ubdc_pkg::BRR_W-1:0]    brr_word,
    output logic                          rate_error
);

    logic                        done_reg;
    logic                        by8_reg;
    logic                        by8_next;
    logic [ubdc_pkg::MANT_W-1:0] mant_reg;
    logic [ubdc_pkg::MANT_W-1:0] mant_next;
    logic [ubdc_pkg::FRAC_W-1:0] frac_reg;
    logic [ubdc_pkg::FRAC_W-1:0] frac_next;
    logic                        err_reg;
    logic                        err_next;
    logic [ubdc_pkg::QUO_W:0]    q_inc;
    logic [ubdc_pkg::QUO_W-1:0]  v;
    logic                        sat;

    // work holds floor(2*clock/rate); (q+1)/2 is the half-up rounded divisor
    assign q_inc = {1'b0, in_data.work} + 1'b1;
    assign v     = q_inc[ubdc_pkg::QUO_W:1];

    always_comb
    begin
        if (in_data.by8)
        begin
            sat = in_data.ovf || (v[ubdc_pkg::QUO_W-1:15] != '0);
        end
        else
        begin
            sat = in_data.ovf || (v[ubdc_pkg::QUO_W-1:16] != '0);
        end
    end

    always_comb
    begin
        by8_next  = in_data.by8;
        err_next  = 1'b0;
        mant_next = v[15:4];
        frac_next = v[3:0];
        if (in_data.by8)
        begin
            mant_next = v[14:3];
            frac_next = {1'b0, v[2:0]};
        end
        if (in_data.zero)
        begin
            by8_next  = 1'b0;
            mant_next = '0;
            frac_next = '0;
            err_next  = 1'b1;
        end
        else if (sat)
        begin
            mant_next = ubdc_pkg::MANT_MAX;
            frac_next = in_data.by8 ? ubdc_pkg::FRAC_MAX_BY8 : ubdc_pkg::FRAC_MAX_BY16;
            err_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        by8_reg  <= by8_next;
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        err_reg  <= err_next;
    end

    assign done            = done_reg;
    assign oversample_by_8 = by8_reg;
    assign mantissa        = mant_reg;
    assign fraction        = frac_reg;
    assign brr_word        = {mant_reg, frac_reg};
    assign rate_error      = err_reg;

endmodule
